@@ rtl/core/msb_first_bitstream_reader_top_macros.svh @@
// Assertion helpers used by the bit reader top module.
`ifndef MSB_FIRST_BITSTREAM_READER_TOP_MACROS_SVH
`define MSB_FIRST_BITSTREAM_READER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define MSBR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("msbr: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define MSBR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("msbr: next-cycle check failed");

`endif

@@ rtl/core/msbr_pkg.sv @@
`timescale 1ns / 1ps

package msbr_pkg;

    localparam int BUFFER_BYTES_DEF   = 1024;
    localparam int MAX_FIELD_BITS_DEF = 64;

    // Byte index carried between modules; wide enough for the largest store.
    localparam int BYTE_IDX_W = 16;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_SKIP   = 2'd2;
    localparam logic [1:0] OP_REWIND = 2'd3;

    typedef struct packed {
        logic                  we;
        logic [BYTE_IDX_W-1:0] addr;
        logic [7:0]            data;
    } load_req_t;

    typedef struct packed {
        logic                  start;
        logic [BYTE_IDX_W-1:0] first_byte;
        logic [2:0]            bit_off;
        logic [6:0]            length;
    } fetch_req_t;

endpackage

@@ rtl/core/msb_first_bitstream_reader_top.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Contents
// s_       in         tuser: opcode; tdata: address, byte, field length, skip count
// m_       out        tdata: field value; tuser: status
// cfg_     in         write of the valid byte count, no read-back
//
// Load, skip, rewind, a zero-length read and a failed read go straight to the finish step.
// A read of nonzero length passes through the fetch step first: the store has one read port and
// the bytes are fetched and merged one per cycle.
// Reset clears the cursor and the byte count; the byte store is not cleared.
// A result held in the output register stalls only the final step of the next request.

`include "msb_first_bitstream_reader_top_macros.svh"

module msb_first_bitstream_reader_top #(
    parameter int BUFFER_BYTES   = msbr_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_FIELD_BITS = msbr_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] byte_address, [17:10] byte_value, [24:18] field_length,
    // [38:25] skip_count, [39] zero
    input  logic [39:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [63:0] field_value
    output logic [63:0] m_tdata,
    // [0] status
    output logic [0:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata
);

    localparam int CUR_W  = $clog2(BUFFER_BYTES * 8 + 2);
    localparam int SZ_W   = ($clog2(BUFFER_BYTES + 1) > 11) ? $clog2(BUFFER_BYTES + 1) : 11;
    localparam int W_A    = (CUR_W > 14) ? CUR_W : 14;
    localparam int W      = ((W_A > SZ_W + 3) ? W_A : SZ_W + 3) + 1;
    localparam int CAP    = BUFFER_BYTES * 8 + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FETCH  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [10:0]      buffer_bytes_reg, buffer_bytes_next;
    logic             res_status_reg, res_status_next;
    logic             res_use_acc_reg, res_use_acc_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [63:0]      m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;

    logic             in_acc;
    logic [1:0]       opcode;
    logic [9:0]       byte_address;
    logic [7:0]       byte_value;
    logic [6:0]       field_length;
    logic [13:0]      skip_count;
    logic [W-1:0]     size_w;
    logic [W-1:0]     end_pos;
    logic [W-1:0]     skip_sum;
    logic [CUR_W-1:0] skip_cur;
    logic             rd_ok;
    logic             out_free;

    msbr_pkg::load_req_t             load_req;
    msbr_pkg::fetch_req_t            fetch_req;
    logic                            fetch_done;
    logic [MAX_FIELD_BITS-1:0]       field_value;

    assign s_tready     = (state_reg == ST_IDLE);
    assign in_acc       = s_tvalid && s_tready;
    assign opcode       = s_tuser;
    assign byte_address = s_tdata[9:0];
    assign byte_value   = s_tdata[17:10];
    assign field_length = s_tdata[24:18];
    assign skip_count   = s_tdata[38:25];
    assign out_free     = !m_tvalid_reg || m_tready;

    // A byte count above the store size counts as the store size.
    always_comb begin
        size_w   = (W'(buffer_bytes_reg) > W'(BUFFER_BYTES)) ? W'(BUFFER_BYTES)
                                                           : W'(buffer_bytes_reg);
        end_pos  = W'(cursor_reg) + W'(field_length);
        rd_ok    = (field_length <= 7'(MAX_FIELD_BITS)) && (end_pos <= (size_w << 3));
        skip_sum = W'(cursor_reg) + W'(skip_count);
        skip_cur = (skip_sum > W'(CAP)) ? CUR_W'(CAP) : skip_sum[CUR_W-1:0];
    end

    always_comb begin
        load_req.we   = in_acc && (opcode == msbr_pkg::OP_LOAD)
                        && (W'(byte_address) < W'(BUFFER_BYTES));
        load_req.addr = msbr_pkg::BYTE_IDX_W'(byte_address);
        load_req.data = byte_value;

        fetch_req.start      = in_acc && (opcode == msbr_pkg::OP_READ) && rd_ok
                               && (field_length != 7'd0);
        fetch_req.first_byte = msbr_pkg::BYTE_IDX_W'(cursor_reg >> 3);
        fetch_req.bit_off    = cursor_reg[2:0];
        fetch_req.length     = field_length;
    end

    msbr_fetch #(
        .BUFFER_BYTES   (BUFFER_BYTES),
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_fetch (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_req    (load_req),
        .fetch_req   (fetch_req),
        .fetch_done  (fetch_done),
        .field_value (field_value)
    );

    always_comb begin
        state_next        = state_reg;
        cursor_next       = cursor_reg;
        buffer_bytes_next = cfg_we ? cfg_wdata : buffer_bytes_reg;
        res_status_next   = res_status_reg;
        res_use_acc_next  = res_use_acc_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    res_status_next  = 1'b0;
                    res_use_acc_next = 1'b0;
                    state_next       = ST_FINISH;
                    case (opcode)
                        msbr_pkg::OP_LOAD: begin
                        end
                        msbr_pkg::OP_READ: begin
                            if (rd_ok) begin
                                cursor_next = end_pos[CUR_W-1:0];
                                if (field_length != 7'd0) begin
                                    res_use_acc_next = 1'b1;
                                    state_next       = ST_FETCH;
                                end
                            end else begin
                                res_status_next = 1'b1;
                            end
                        end
                        msbr_pkg::OP_SKIP: begin
                            cursor_next = skip_cur;
                        end
                        msbr_pkg::OP_REWIND: begin
                            cursor_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                if (fetch_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_use_acc_reg ? 64'(field_value) : 64'd0;
                    m_tuser_next  = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cursor_reg       <= '0;
            buffer_bytes_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            cursor_reg       <= cursor_next;
            buffer_bytes_reg <= buffer_bytes_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
        res_status_reg  <= res_status_next;
        res_use_acc_reg <= res_use_acc_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    `MSBR_ASSERT_IMP(a_cursor_capped, aclk, aresetn, 1'b1, cursor_reg <= CUR_W'(CAP))
    `MSBR_ASSERT_NXT(a_busy_after_request, aclk, aresetn, in_acc, !s_tready)
    `MSBR_ASSERT_IMP(a_done_in_fetch, aclk, aresetn, fetch_done, state_reg == ST_FETCH)
    `MSBR_ASSERT_IMP(a_fail_zero_value, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 64'd0)

endmodule

@@ rtl/core/msbr_fetch.sv @@
`timescale 1ns / 1ps

module msbr_fetch #(
    parameter int BUFFER_BYTES   = msbr_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_FIELD_BITS = msbr_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  msbr_pkg::load_req_t        load_req,
    input  msbr_pkg::fetch_req_t       fetch_req,
    output logic                       fetch_done,
    output logic [MAX_FIELD_BITS-1:0]  field_value
);

    localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

    logic [7:0]                mem [BUFFER_BYTES];
    logic [7:0]                rdata_reg;

    logic                      busy_reg, busy_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic [3:0]                issue_cnt_reg, issue_cnt_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic [2:0]                off_reg, off_next;
    logic                      first_reg, first_next;
    logic [6:0]                rem_reg, rem_next;
    logic [MAX_FIELD_BITS-1:0] acc_reg, acc_next;

    logic                      rd_en;
    logic [7:0]                nb_sum;
    logic [3:0]                avail;
    logic [3:0]                take_n;
    logic [7:0]                aligned;
    logic [7:0]                chunk;
    logic                      last_take;

    // One read port: the store is written by load requests and read one byte a cycle.
    always_ff @(posedge aclk) begin
        if (load_req.we) begin
            mem[load_req.addr[ADDR_W-1:0]] <= load_req.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[addr_reg];
        end
    end

    assign rd_en = busy_reg && (issue_cnt_reg != 4'd0);

    // The first byte yields only the bits from the start offset down; later ones yield up to eight.
    always_comb begin
        nb_sum    = 8'(fetch_req.length) + 8'(fetch_req.bit_off) + 8'd7;
        avail     = first_reg ? (4'd8 - {1'b0, off_reg}) : 4'd8;
        take_n    = ({3'b000, avail} > rem_reg) ? rem_reg[3:0] : avail;
        aligned   = first_reg ? (rdata_reg << off_reg) : rdata_reg;
        chunk     = aligned >> (4'd8 - take_n);
        last_take = rd_valid_reg && (rem_reg == {3'b000, take_n});
    end

    always_comb begin
        busy_next      = busy_reg;
        addr_next      = addr_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_valid_next  = rd_en;
        off_next       = off_reg;
        first_next     = first_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        if (fetch_req.start) begin
            busy_next      = 1'b1;
            addr_next      = fetch_req.first_byte[ADDR_W-1:0];
            issue_cnt_next = nb_sum[6:3];
            rd_valid_next  = 1'b0;
            off_next       = fetch_req.bit_off;
            first_next     = 1'b1;
            rem_next       = fetch_req.length;
            acc_next       = '0;
        end else if (busy_reg) begin
            if (rd_en) begin
                addr_next      = addr_reg + ADDR_W'(1);
                issue_cnt_next = issue_cnt_reg - 4'd1;
            end
            if (rd_valid_reg) begin
                acc_next   = (acc_reg << take_n) | MAX_FIELD_BITS'(chunk);
                rem_next   = rem_reg - 7'(take_n);
                first_next = 1'b0;
            end
            if (last_take) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            rd_valid_reg <= rd_valid_next;
        end
        addr_reg      <= addr_next;
        issue_cnt_reg <= issue_cnt_next;
        off_reg       <= off_next;
        first_reg     <= first_next;
        rem_reg       <= rem_next;
        acc_reg       <= acc_next;
    end

    assign fetch_done  = busy_reg && last_take;
    assign field_value = acc_reg;

endmodule
